>>> rtl/core/tcmf_pkg.sv
// ----------------------------------------------------------------------------
// tcmf_pkg
// Shared widths, status codes and fixed-point limits for the mixture fit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcmf_pkg;

    // Field widths
    localparam int unsigned PURITY_W = 16;
    localparam int unsigned MEAS_W   = 32;
    localparam int unsigned INDEX_W  = 6;
    localparam int unsigned COEF_W   = 40;
    localparam int unsigned STATUS_W = 2;

    // Accumulator widths
    localparam int unsigned SUM_P_W  = 38;
    localparam int unsigned SUM_M_W  = 54;
    localparam int unsigned COUNT_W  = 7;

    // Solver widths
    localparam int unsigned PROD_W   = 92;   // 54 x 38 bit product
    localparam int unsigned DET_W    = 76;   // 38 x 38 bit product
    localparam int unsigned DIVD_W   = PROD_W + 16;
    localparam int unsigned DIV_CNT_W = 7;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SINGULAR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Signed 40-bit limits
    localparam logic [COEF_W-1:0] COEF_POS = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_NEG = {1'b1, {(COEF_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> rtl/core/tcmf_if.sv
// ----------------------------------------------------------------------------
// tcmf_smp_if / tcmf_fit_if
// Valid/ready channels for input samples and fitted result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcmf_smp_if;
    logic                            valid;
    logic                            ready;
    logic [tcmf_pkg::PURITY_W-1:0]   purity;
    logic [tcmf_pkg::MEAS_W-1:0]     measurement;
    logic                            last;

    modport source (output valid, output purity, output measurement, output last,
                    input ready);
    modport sink   (input valid, input purity, input measurement, input last,
                    output ready);
endinterface

interface tcmf_fit_if;
    logic                            valid;
    logic                            ready;
    logic [tcmf_pkg::INDEX_W-1:0]    sample_index;
    logic signed [tcmf_pkg::COEF_W-1:0] fitted_value;
    logic signed [tcmf_pkg::COEF_W-1:0] coef_pure;
    logic signed [tcmf_pkg::COEF_W-1:0] coef_other;
    logic [tcmf_pkg::STATUS_W-1:0]   status;
    logic                            last_of_run;

    modport source (output valid, output sample_index, output fitted_value,
                    output coef_pure, output coef_other, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input sample_index, input fitted_value,
                    input coef_pure, input coef_other, input status,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/core/two_component_mixture_fit.sv
// ----------------------------------------------------------------------------
// two_component_mixture_fit
// Accumulates least-squares sums over a set of samples, solves the 2x2
// normal equations on the last sample and emits one fitted item per stored sample.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | payload
//  i_smp    | in  | valid/ready | purity, measurement, last
//  o_fit    | out | valid/ready | sample_index, fitted_value, coef_pure,
//           |     |             | coef_other, status, last_of_run
//
//  A sample passes through multiply and saturating add, then back to idle.
//  The solve forms six products from 54x16 partial products, then two 108-step
//  restoring divisions (one quotient bit a cycle).
//  Each result steps through purity memory read, multiply, then sum and load.
//  Reset clears the sums and the sequencer; the purity memory is not cleared.
//  A stalled output holds the emit sequencer; samples are taken only in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module two_component_mixture_fit #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    tcmf_smp_if.sink  i_smp,
    tcmf_fit_if.source o_fit
);
    import tcmf_pkg::*;

    localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACC_MUL, ST_ACC_ADD, ST_SOLVE_MUL, ST_SOLVE_STORE,
        ST_SOLVE_CHECK, ST_DIV, ST_DIV_DONE, ST_EMIT_RD, ST_EMIT_MUL, ST_EMIT_SUM
    } t_state;

    t_state r_state;

    // Sums and set bookkeeping
    logic [SUM_P_W-1:0]  r_sum_pp, r_sum_pq, r_sum_qq;
    logic [SUM_M_W-1:0]  r_sum_mp, r_sum_mq;
    logic [COUNT_W-1:0]  r_count;
    logic                r_overflow;

    // Captured sample and products
    logic [PURITY_W-1:0] r_p;
    logic [MEAS_W-1:0]   r_m;
    logic                r_last;
    logic [31:0]         r_t_pp;
    logic [32:0]         r_t_pq;
    logic [33:0]         r_t_qq;
    logic [47:0]         r_t_mp;
    logic [48:0]         r_t_mq;

    // Solver
    logic [2:0]          r_idx;
    logic [1:0]          r_chunk;
    logic [PROD_W-1:0]   r_acc, r_first;
    logic [DET_W-1:0]    r_det;
    logic                r_nx_neg, r_ny_neg;
    logic [PROD_W-1:0]   r_nx_mag, r_ny_mag;
    logic [DET_W-1:0]    r_rem;
    logic [DIVD_W-1:0]   r_dq;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                r_div_y;
    logic signed [COEF_W-1:0] r_coef_x, r_coef_y;
    logic [STATUS_W-1:0] r_status;

    // Emit
    logic [COUNT_W-1:0]  r_k;
    logic [PURITY_W-1:0] r_rd_p;
    logic signed [56:0]  r_fx, r_fy;

    // Output register
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_idx;
    logic signed [COEF_W-1:0] r_out_fit;
    logic signed [COEF_W-1:0] r_out_x, r_out_y;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_last;

    // Purity memory
    logic [PURITY_W-1:0] r_mem [MAX_SAMPLES];

    logic                w_accept, w_room;
    logic [16:0]         w_q;
    logic [SUM_M_W-1:0]  w_opa;
    logic [47:0]         w_opb;
    logic [15:0]         w_chunk;
    logic [69:0]         w_part;
    logic                w_ge;
    logic [PROD_W-1:0]   w_mag;
    logic [DET_W:0]      w_trial;
    logic                w_trial_ge;
    logic                w_qbig, w_qneg;
    logic [COEF_W-1:0]   w_qsat;
    logic                w_singular;
    logic signed [57:0]  w_fsum, w_fadj;
    logic signed [41:0]  w_fsh;
    logic [COEF_W-1:0]   w_fit;
    logic                w_out_free;
    logic                w_out_load;
    logic [16:0]         w_rd_q;

    // Saturating adds: a carry out of the sum width clamps to all ones
    function automatic logic [SUM_P_W-1:0] sat_p(input logic [SUM_P_W-1:0] s,
                                                 input logic [SUM_P_W-1:0] v);
        logic [SUM_P_W:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[SUM_P_W] ? {SUM_P_W{1'b1}} : t[SUM_P_W-1:0];
    endfunction

    function automatic logic [SUM_M_W-1:0] sat_m(input logic [SUM_M_W-1:0] s,
                                                 input logic [SUM_M_W-1:0] v);
        logic [SUM_M_W:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[SUM_M_W] ? {SUM_M_W{1'b1}} : t[SUM_M_W-1:0];
    endfunction

    assign i_smp.ready = (r_state == ST_IDLE);
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign w_room      = (r_count < COUNT_W'(MAX_SAMPLES));
    assign w_q         = 17'h10000 - {1'b0, r_p};

    // Pick operands of the shared 54x16 partial-product multiplier
    always_comb begin
        case (r_idx)
            3'd0:    begin w_opa = SUM_M_W'(r_sum_pp); w_opb = 48'(r_sum_qq); end
            3'd1:    begin w_opa = SUM_M_W'(r_sum_pq); w_opb = 48'(r_sum_pq); end
            3'd2:    begin w_opa = r_sum_mp;           w_opb = 48'(r_sum_qq); end
            3'd3:    begin w_opa = r_sum_mq;           w_opb = 48'(r_sum_pq); end
            3'd4:    begin w_opa = r_sum_mq;           w_opb = 48'(r_sum_pp); end
            default: begin w_opa = r_sum_mp;           w_opb = 48'(r_sum_pq); end
        endcase
        case (r_chunk)
            2'd0:    w_chunk = w_opb[15:0];
            2'd1:    w_chunk = w_opb[31:16];
            default: w_chunk = w_opb[47:32];
        endcase
    end
    assign w_part = 70'(w_opa) * 70'(w_chunk);

    // Difference of a product pair
    assign w_ge  = (r_first >= r_acc);
    assign w_mag = w_ge ? (r_first - r_acc) : (r_acc - r_first);

    // Restoring division step and quotient saturation
    assign w_trial    = {r_rem, r_dq[DIVD_W-1]};
    assign w_trial_ge = (w_trial >= {1'b0, r_det});
    assign w_qbig     = |r_dq[DIVD_W-1:COEF_W-1];
    assign w_qneg     = r_div_y ? r_ny_neg : r_nx_neg;
    always_comb begin
        if (w_qneg) begin
            w_qsat = w_qbig ? COEF_NEG : (COEF_W'(0) - r_dq[COEF_W-1:0]);
        end else begin
            w_qsat = w_qbig ? COEF_POS : r_dq[COEF_W-1:0];
        end
    end

    assign w_singular = (r_det == '0) || (r_sum_pp == '0) || (r_sum_pq == '0);

    // Fitted value: sum, truncate toward zero, clamp
    assign w_fsum = 58'(r_fx) + 58'(r_fy);
    assign w_fadj = w_fsum + (w_fsum[57] ? 58'sd65535 : 58'sd0);
    assign w_fsh  = 42'(w_fadj >>> 16);
    always_comb begin
        if (w_fsh > 42'(signed'(COEF_POS)))      w_fit = COEF_POS;
        else if (w_fsh < 42'(signed'(COEF_NEG))) w_fit = COEF_NEG;
        else                                      w_fit = w_fsh[COEF_W-1:0];
    end
    assign w_rd_q     = 17'h10000 - {1'b0, r_rd_p};
    assign w_out_free = !r_out_valid || o_fit.ready;
    assign w_out_load = (r_state == ST_EMIT_SUM) && w_out_free;

    // Purity memory: write on accept while there is room, registered read
    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            r_mem[r_count[AW-1:0]] <= i_smp.purity;
        end
        if (r_state == ST_EMIT_RD) begin
            r_rd_p <= r_mem[r_k[AW-1:0]];
        end
    end

    // Sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum_pp    <= '0;
            r_sum_pq    <= '0;
            r_sum_qq    <= '0;
            r_sum_mp    <= '0;
            r_sum_mq    <= '0;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load the output register from the emit step, drop it once taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_fit.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_p    <= i_smp.purity;
                        r_m    <= i_smp.measurement;
                        r_last <= i_smp.last;
                        r_idx  <= '0;
                        r_chunk <= '0;
                        r_acc  <= '0;
                        if (w_room) begin
                            r_state <= ST_ACC_MUL;
                        end else begin
                            r_overflow <= 1'b1;
                            r_state    <= i_smp.last ? ST_SOLVE_MUL : ST_IDLE;
                        end
                    end
                end
                ST_ACC_MUL: begin
                    r_t_pp  <= 32'(r_p) * 32'(r_p);
                    r_t_pq  <= 33'(r_p) * 33'(w_q);
                    r_t_qq  <= 34'(w_q) * 34'(w_q);
                    r_t_mp  <= 48'(r_m) * 48'(r_p);
                    r_t_mq  <= 49'(r_m) * 49'(w_q);
                    r_state <= ST_ACC_ADD;
                end
                ST_ACC_ADD: begin
                    r_sum_pp <= sat_p(r_sum_pp, SUM_P_W'(r_t_pp));
                    r_sum_pq <= sat_p(r_sum_pq, SUM_P_W'(r_t_pq));
                    r_sum_qq <= sat_p(r_sum_qq, SUM_P_W'(r_t_qq));
                    r_sum_mp <= sat_m(r_sum_mp, SUM_M_W'(r_t_mp));
                    r_sum_mq <= sat_m(r_sum_mq, SUM_M_W'(r_t_mq));
                    r_count  <= r_count + COUNT_W'(1);
                    r_state  <= r_last ? ST_SOLVE_MUL : ST_IDLE;
                end
                ST_SOLVE_MUL: begin
                    r_acc <= r_acc + (PROD_W'(w_part) << {r_chunk, 4'd0});
                    if (r_chunk == 2'd2) begin
                        r_chunk <= '0;
                        r_state <= ST_SOLVE_STORE;
                    end else begin
                        r_chunk <= r_chunk + 2'd1;
                    end
                end
                ST_SOLVE_STORE: begin
                    r_acc <= '0;
                    case (r_idx)
                        3'd0, 3'd2, 3'd4: r_first <= r_acc;
                        3'd1: r_det <= w_ge ? DET_W'(w_mag) : '0;
                        3'd3: begin r_nx_neg <= !w_ge; r_nx_mag <= w_mag; end
                        default: begin r_ny_neg <= !w_ge; r_ny_mag <= w_mag; end
                    endcase
                    if (r_idx == 3'd5) begin
                        r_state <= ST_SOLVE_CHECK;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= ST_SOLVE_MUL;
                    end
                end
                ST_SOLVE_CHECK: begin
                    r_k <= '0;
                    if (r_overflow)      r_status <= STATUS_OVERFLOW;
                    else if (w_singular) r_status <= STATUS_SINGULAR;
                    else                 r_status <= STATUS_OK;
                    if (w_singular) begin
                        r_coef_x <= '0;
                        r_coef_y <= '0;
                        r_state  <= ST_EMIT_RD;
                    end else begin
                        r_rem     <= '0;
                        r_dq      <= {r_nx_mag, 16'd0};
                        r_div_cnt <= '0;
                        r_div_y   <= 1'b0;
                        r_state   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_trial_ge ? DET_W'(w_trial - {1'b0, r_det}) : DET_W'(w_trial);
                    r_dq  <= {r_dq[DIVD_W-2:0], w_trial_ge};
                    if (r_div_cnt == DIV_CNT_W'(DIVD_W - 1)) begin
                        r_state <= ST_DIV_DONE;
                    end else begin
                        r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    end
                end
                ST_DIV_DONE: begin
                    if (!r_div_y) begin
                        r_coef_x  <= w_qsat;
                        r_rem     <= '0;
                        r_dq      <= {r_ny_mag, 16'd0};
                        r_div_cnt <= '0;
                        r_div_y   <= 1'b1;
                        r_state   <= ST_DIV;
                    end else begin
                        r_coef_y <= w_qsat;
                        r_state  <= ST_EMIT_RD;
                    end
                end
                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_MUL;
                end
                ST_EMIT_MUL: begin
                    r_fx    <= r_coef_x * $signed({1'b0, r_rd_p});
                    r_fy    <= r_coef_y * $signed({1'b0, w_rd_q});
                    r_state <= ST_EMIT_SUM;
                end
                ST_EMIT_SUM: begin
                    if (w_out_free) begin
                        r_out_idx    <= INDEX_W'(r_k);
                        r_out_fit    <= w_fit;
                        r_out_x      <= r_coef_x;
                        r_out_y      <= r_coef_y;
                        r_out_status <= r_status;
                        r_out_last   <= (r_k + COUNT_W'(1) == r_count);
                        r_k          <= r_k + COUNT_W'(1);
                        if (r_k + COUNT_W'(1) == r_count) begin
                            r_sum_pp   <= '0;
                            r_sum_pq   <= '0;
                            r_sum_qq   <= '0;
                            r_sum_mp   <= '0;
                            r_sum_mq   <= '0;
                            r_count    <= '0;
                            r_overflow <= 1'b0;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_fit.valid        = r_out_valid;
    assign o_fit.sample_index = r_out_idx;
    assign o_fit.fitted_value = r_out_fit;
    assign o_fit.coef_pure    = r_out_x;
    assign o_fit.coef_other   = r_out_y;
    assign o_fit.status       = r_out_status;
    assign o_fit.last_of_run  = r_out_last;

endmodule

`default_nettype wire
